// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and codes for the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] payload_offset;
        logic [9:0] granted_size;
    } t_result;

endpackage

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// first-fit allocator over an implicit header list held in one memory
// ----------------------------------------------------------------------------
// allocate reads and checks each header from offset zero until one fits, and
// writes a second header when the block is split; free marks its header free,
// then makes a merge pass over the chain; a null free or one below a header
// goes straight to the result. one request in flight; the next transaction is
// taken the cycle after the result is accepted. reset: a clearing pass writes
// every entry, offset zero as one free block; no request is taken until it finishes.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode, [10:1] req_size, [20:11] release_offset, [23:21] zero
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // null_pointer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [11:2] payload_offset, [21:12] granted_size, [23:22] zero
    output logic [23:0] m_axis_tdata
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = AW + 2;  // position with headroom for overflow
    localparam int CW = (PW > 11) ? PW : 11;  // compare width for 10-bit fields
    localparam logic [PW-1:0] HEAP_P = PW'(HEAP_BYTES);
    localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ARD    = 4'd2;
    localparam logic [3:0] S_ACHK   = 4'd3;
    localparam logic [3:0] S_ASPLIT = 4'd4;
    localparam logic [3:0] S_MRDL   = 4'd5;
    localparam logic [3:0] S_MLW    = 4'd6;
    localparam logic [3:0] S_MRDP   = 4'd7;
    localparam logic [3:0] S_MCHK   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // entry: [AW:1] size, [0] free
    logic [AW:0]   r_mem [HEAP_BYTES];
    logic [AW:0]   r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   wr_data;

    logic [3:0]    r_state;
    logic [PW-1:0] r_pos, r_left;
    logic [AW-1:0] r_lsize;
    logic          r_lfree;
    logic [9:0]    r_want;
    ffha_pkg::t_result r_res;
    logic          r_ovalid;

    logic [AW-1:0] rd_size;
    logic          rd_free;
    logic [PW-1:0] next_pos, step;
    logic [PW-1:0] rest;
    logic          fit, split;

    assign rd_size = r_rd[AW:1];
    assign rd_free = r_rd[0];
    assign step     = PW'(rd_size) + HDR_P;
    assign next_pos = r_pos + step;
    assign rest     = r_pos + PW'(r_want) + HDR_P;
    assign fit      = rd_free && (CW'(r_want) <= CW'(rd_size));
    assign split    = CW'(rd_size) > CW'(r_want) + CW'(HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_res.granted_size, r_res.payload_offset, r_res.status};

    always_comb begin
        rd_addr = r_pos[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                wr_data = (r_pos == '0) ? {AW'(HEAP_BYTES - HEADER_BYTES), 1'b1} : '0;
            end
            S_ACHK: begin
                if (fit) begin
                    wr_en = 1'b1;
                    if (split) begin
                        wr_data = {AW'(r_want), 1'b0};
                    end else begin
                        wr_data = {rd_size, 1'b0};
                    end
                end
            end
            S_ASPLIT: begin
                wr_addr = rest[AW-1:0];
                wr_en   = rest < HEAP_P;
                wr_data = {r_lsize, 1'b1};
            end
            S_MRDL: begin
                rd_addr = r_left[AW-1:0];
            end
            S_MLW: begin
                // freed header: keep size, set free mark
                wr_addr = r_left[AW-1:0];
                wr_en = 1'b1;
                wr_data = {rd_size, 1'b1};
            end
            S_MCHK: begin
                if (r_pos != '0 && (!(r_lfree && rd_free) || (next_pos >= HEAP_P))) begin
                    // close out the left block before moving on
                    wr_en   = 1'b1;
                    wr_addr = r_left[AW-1:0];
                    wr_data = (r_lfree && rd_free)
                            ? {r_lsize + AW'(step), 1'b1} : {r_lsize, r_lfree};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == HEAP_P - 1'b1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_want <= s_axis_tdata[10:1];
                        r_pos  <= '0;
                        if (s_axis_tdata[0] == ffha_pkg::MODE_ALLOC) begin
                            r_res   <= '0;
                            r_state <= S_ARD;
                        end else if (s_axis_tuser) begin
                            r_res   <= {ffha_pkg::ST_NULL, 20'd0};
                            r_state <= S_OUT;
                        end else if (CW'(s_axis_tdata[20:11]) >= CW'(HEADER_BYTES) &&
                                     CW'(s_axis_tdata[20:11]) - CW'(HEADER_BYTES)
                                     < CW'(HEAP_BYTES)) begin
                            r_res   <= '0;
                            r_left  <= PW'(CW'(s_axis_tdata[20:11]) - CW'(HEADER_BYTES));
                            r_state <= S_MRDL;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    if (fit) begin
                        r_res.payload_offset <= 10'(r_pos + HDR_P);
                        if (split) begin
                            r_res.granted_size <= r_want;
                            r_lsize <= rd_size - AW'(r_want) - AW'(HEADER_BYTES);
                            r_state <= S_ASPLIT;
                        end else begin
                            r_res.granted_size <= 10'(rd_size);
                            r_state <= S_OUT;
                        end
                    end else if (next_pos + HDR_P >= HEAP_P) begin
                        r_res.status <= ffha_pkg::ST_NOSPACE;
                        r_state <= S_OUT;
                    end else begin
                        r_pos <= next_pos;
                        r_state <= S_ARD;
                    end
                end
                S_ASPLIT: r_state <= S_OUT;
                S_MRDL: begin
                    // read the freed header to learn its size
                    r_state <= S_MLW;
                end
                S_MLW: begin
                    // merge pass starts at offset zero
                    r_pos   <= '0;
                    r_state <= S_MRDP;
                end
                S_MRDP: begin
                    r_state <= S_MCHK;
                end
                S_MCHK: begin
                    if (r_pos == '0) begin
                        // pass start: left block is offset zero
                        r_left  <= '0;
                        r_lsize <= rd_size;
                        r_lfree <= rd_free;
                    end else if (r_lfree && rd_free) begin
                        r_lsize <= r_lsize + AW'(step);
                    end else begin
                        r_left  <= r_pos;
                        r_lsize <= rd_size;
                        r_lfree <= rd_free;
                    end
                    r_pos <= next_pos;
                    if (next_pos >= HEAP_P) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MRDP;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
